### rtl/core/fdcd_pkg.sv
// Shared types and constants of the flip-dot column driver.
// Item, drive-word and register-write beat layouts; no dependencies.
package fdcd_pkg;

    localparam logic       ACT_SELECT    = 1'b0;
    localparam logic       ACT_RENDER    = 1'b1;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_BAD_PANEL  = 2'd1;
    localparam logic [1:0] STATUS_BAD_COLUMN = 2'd2;

    localparam logic [1:0] REG_DIFFERENTIAL  = 2'd0;
    localparam logic [1:0] REG_PANEL_COUNT   = 2'd1;
    localparam logic [1:0] REG_TOTAL_COLUMNS = 2'd2;

    localparam logic [4:0] NO_SELECT  = 5'h1F;
    localparam logic [7:0] SHORT_WAIT = 8'd2;

    typedef struct packed {
        logic        action;
        logic [2:0]  panel;
        logic [7:0]  column_index;
        logic [15:0] column_bits;
        logic [7:0]  pre_wait;
        logic [7:0]  clear_wait;
        logic [7:0]  set_wait;
    } t_in_item;

    typedef struct packed {
        logic [4:0]  select_lines;
        logic        clock_line;
        logic        reset_line;
        logic        clear_line;
        logic [15:0] row_lines;
        logic [7:0]  wait_before;
        logic [1:0]  status;
        logic [31:0] flips_total;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [1:0] index;
        logic [7:0] value;
    } t_cfg_write;

endpackage

### rtl/core/fdcd_stream_if.sv
// Valid/ready channel carrying one payload beat per handshake.
// Payload type is set at instantiation, normally a struct from fdcd_pkg.
interface fdcd_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/fdcd_column_store.sv
// Old-column store: synchronous RAM with per-entry valid bits and write forwarding.
// Unwritten entries read as zero; depends on nothing but its parameter.
module fdcd_column_store #(
    parameter int COLUMNS = 128
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_rd_en,
    input  logic [((COLUMNS > 1) ? $clog2(COLUMNS) : 1)-1:0] i_rd_idx,
    input  logic                                   i_wr_en,
    input  logic [((COLUMNS > 1) ? $clog2(COLUMNS) : 1)-1:0] i_wr_idx,
    input  logic [15:0]                            i_wr_data,
    output logic [15:0]                            o_rd_data
);
    logic [15:0]        r_mem [COLUMNS];
    logic [COLUMNS-1:0] r_valid;
    logic [15:0]        r_q;
    logic               r_q_valid;
    logic               r_fwd;
    logic [15:0]        r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q        <= r_mem[i_rd_idx];
            r_fwd_data <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_q_valid <= 1'b0;
            r_fwd     <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_idx] <= 1'b1;
            end
            if (i_rd_en) begin
                r_q_valid <= r_valid[i_rd_idx];
                r_fwd     <= i_wr_en && (i_wr_idx == i_rd_idx);
            end
        end
    end

    assign o_rd_data = r_fwd ? r_fwd_data : (r_q_valid ? r_q : 16'd0);

endmodule

### rtl/core/flip_dot_column_driver.sv
// Flip-dot column driver top level: item intake, column store, drive-word sequencer.
// Depends on fdcd_pkg, fdcd_stream_if and fdcd_column_store.
//
// A select item yields two drive words, a render item six (five when the clear
// pulse is skipped), a rejected item one word with its status. Words leave one
// per cycle from an output register while the receiver is ready; the next item is
// taken in while the current one is still being sent. The old-column RAM is read
// as an item is accepted into the intake register; the flip comparison, flip
// count and write-back happen as it moves into the sequencer, whose words then
// load the output register. The old-column store is cleared at reset at once
// through per-entry valid bits; there is no clearing pass. Configuration writes
// are taken every cycle.
module flip_dot_column_driver
    import fdcd_pkg::*;
#(
    parameter int COLUMNS = 128
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fdcd_stream_if.sink   i_item,
    fdcd_stream_if.source o_word,
    fdcd_stream_if.sink   i_cfg
);
    localparam int AW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

    typedef enum logic [3:0] {
        ST_ERROR,
        ST_SEL_RESET,
        ST_SEL_PANEL,
        ST_PRE,
        ST_CLR_ON,
        ST_CLR_OFF,
        ST_LOW,
        ST_ROWS,
        ST_SET_END
    } t_step;

    function automatic logic [4:0] count_ones(input logic [15:0] v);
        logic [4:0] n;
        n = 5'd0;
        for (int b = 0; b < 16; b++) begin
            n = n + {4'd0, v[b]};
        end
        return n;
    endfunction

    // configuration
    logic       r_diff;
    logic [2:0] r_panels;
    logic [7:0] r_total;

    // intake stage
    logic       r_s1_valid;
    t_in_item   r_s1;

    // sequencer stage
    logic        r_s2_valid;
    t_step       r_step;
    logic [2:0]  r_s2_panel;
    logic [15:0] r_s2_col;
    logic [7:0]  r_s2_pre;
    logic [7:0]  r_s2_clr;
    logic [7:0]  r_s2_set;
    logic        r_s2_omit_clear;
    logic        r_s2_omit_set;
    logic [1:0]  r_s2_status;
    logic [31:0] r_s2_flips;

    // drive images and counter
    logic [4:0]  r_sel;
    logic        r_clock;
    logic        r_reset;
    logic        r_clear;
    logic [15:0] r_rows;
    logic [31:0] r_flips;

    logic        r_out_valid;
    t_out_item   r_out;

    logic        in_accept;
    logic        xfer;
    logic        load;
    logic        store_wr;
    logic [15:0] old_bits;
    logic [15:0] flip_bits;
    logic [4:0]  changed;
    logic        bad_panel;
    logic        bad_col;
    logic        omit_clear;
    logic        omit_set;
    logic [31:0] flips_next;
    t_step       first_step;
    logic [1:0]  first_status;

    logic [4:0]  w_sel;
    logic        w_clock;
    logic        w_reset;
    logic        w_clear;
    logic [15:0] w_rows;
    logic [7:0]  w_wait;
    logic        w_last;
    t_step       w_next;

    fdcd_column_store #(.COLUMNS(COLUMNS)) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_accept),
        .i_rd_idx  (i_item.data.column_index[AW-1:0]),
        .i_wr_en   (store_wr),
        .i_wr_idx  (r_s1.column_index[AW-1:0]),
        .i_wr_data (r_s1.column_bits),
        .o_rd_data (old_bits)
    );

    assign load      = r_s2_valid && (!r_out_valid || o_word.ready);
    assign xfer      = r_s1_valid && (!r_s2_valid || (load && w_last));
    assign in_accept = i_item.valid && i_item.ready;

    assign i_item.ready = !r_s1_valid || xfer;
    assign i_cfg.ready  = 1'b1;
    assign o_word.valid = r_out_valid;
    assign o_word.data  = r_out;

    assign bad_panel  = (r_s1.action == ACT_SELECT) && (r_s1.panel >= r_panels);
    assign bad_col    = (r_s1.action == ACT_RENDER) &&
                        ((r_s1.column_index >= r_total) ||
                         ({1'b0, r_s1.column_index} >= 9'(COLUMNS)));
    assign flip_bits  = old_bits ^ r_s1.column_bits;
    assign changed    = count_ones(flip_bits);
    assign omit_clear = r_diff && ((old_bits & ~r_s1.column_bits) == 16'd0);
    assign omit_set   = r_diff && ((r_s1.column_bits == 16'd0) || (flip_bits == 16'd0));
    assign store_wr   = xfer && (r_s1.action == ACT_RENDER) && !bad_col;
    assign flips_next = r_flips + (store_wr ? {27'd0, changed} : 32'd0);

    always_comb begin
        if (bad_panel) begin
            first_step   = ST_ERROR;
            first_status = STATUS_BAD_PANEL;
        end else if (bad_col) begin
            first_step   = ST_ERROR;
            first_status = STATUS_BAD_COLUMN;
        end else if (r_s1.action == ACT_SELECT) begin
            first_step   = ST_SEL_RESET;
            first_status = STATUS_OK;
        end else begin
            first_step   = ST_PRE;
            first_status = STATUS_OK;
        end
    end

    always_comb begin
        w_sel   = r_sel;
        w_clock = r_clock;
        w_reset = r_reset;
        w_clear = r_clear;
        w_rows  = r_rows;
        w_wait  = 8'd0;
        w_last  = 1'b0;
        w_next  = r_step;
        unique case (r_step)
            ST_ERROR: begin
                w_last = 1'b1;
            end
            ST_SEL_RESET: begin
                w_sel   = NO_SELECT;
                w_clock = 1'b1;
                w_reset = 1'b0;
                w_clear = 1'b0;
                w_rows  = 16'd0;
                w_next  = ST_SEL_PANEL;
            end
            ST_SEL_PANEL: begin
                w_sel   = ~(5'b00001 << r_s2_panel);
                w_reset = 1'b1;
                w_wait  = SHORT_WAIT;
                w_last  = 1'b1;
            end
            ST_PRE: begin
                w_clock = 1'b0;
                w_wait  = r_s2_pre;
                w_next  = ST_CLR_ON;
            end
            ST_CLR_ON: begin
                w_sel   = NO_SELECT;
                w_clock = 1'b1;
                if (!r_s2_omit_clear) begin
                    w_clear = 1'b1;
                end
                w_next  = r_s2_omit_clear ? ST_LOW : ST_CLR_OFF;
            end
            ST_CLR_OFF: begin
                w_clear = 1'b0;
                w_wait  = r_s2_clr;
                w_next  = ST_LOW;
            end
            ST_LOW: begin
                w_clock = 1'b0;
                w_wait  = r_s2_omit_clear ? SHORT_WAIT : 8'd0;
                w_next  = ST_ROWS;
            end
            ST_ROWS: begin
                w_clock = 1'b1;
                w_rows  = r_s2_col;
                w_next  = ST_SET_END;
            end
            ST_SET_END: begin
                w_rows = 16'd0;
                w_wait = r_s2_omit_set ? SHORT_WAIT : r_s2_set;
                w_last = 1'b1;
            end
            default: begin
                w_last = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diff      <= 1'b0;
            r_panels    <= 3'd1;
            r_total     <= 8'd0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_step      <= ST_ERROR;
            r_out_valid <= 1'b0;
            r_sel       <= NO_SELECT;
            r_clock     <= 1'b1;
            r_reset     <= 1'b1;
            r_clear     <= 1'b0;
            r_rows      <= 16'd0;
            r_flips     <= 32'd0;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.data.index)
                    REG_DIFFERENTIAL:  r_diff   <= i_cfg.data.value[0];
                    REG_PANEL_COUNT:   r_panels <= i_cfg.data.value[2:0];
                    REG_TOTAL_COLUMNS: r_total  <= i_cfg.data.value;
                    default: ;
                endcase
            end

            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (xfer) begin
                r_s1_valid <= 1'b0;
            end

            if (store_wr) begin
                r_flips <= flips_next;
            end

            if (xfer) begin
                r_s2_valid <= 1'b1;
                r_step     <= first_step;
            end else if (load && w_last) begin
                r_s2_valid <= 1'b0;
            end else if (load) begin
                r_step <= w_next;
            end

            if (load) begin
                r_out_valid <= 1'b1;
                r_sel       <= w_sel;
                r_clock     <= w_clock;
                r_reset     <= w_reset;
                r_clear     <= w_clear;
                r_rows      <= w_rows;
            end else if (o_word.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1 <= i_item.data;
        end
        if (xfer) begin
            r_s2_panel      <= r_s1.panel;
            r_s2_col        <= r_s1.column_bits;
            r_s2_pre        <= r_s1.pre_wait;
            r_s2_clr        <= r_s1.clear_wait;
            r_s2_set        <= r_s1.set_wait;
            r_s2_omit_clear <= omit_clear;
            r_s2_omit_set   <= omit_set;
            r_s2_status     <= first_status;
            r_s2_flips      <= flips_next;
        end
        if (load) begin
            r_out.select_lines <= w_sel;
            r_out.clock_line   <= w_clock;
            r_out.reset_line   <= w_reset;
            r_out.clear_line   <= w_clear;
            r_out.row_lines    <= w_rows;
            r_out.wait_before  <= w_wait;
            r_out.status       <= r_s2_status;
            r_out.flips_total  <= r_s2_flips;
            r_out.last         <= w_last;
        end
    end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for flip_dot_column_driver: directed table, then random phases.
// Depends on fdcd_pkg, fdcd_stream_if and the flip_dot_column_driver RTL.
module testbench;
    import fdcd_pkg::*;

    localparam int COLUMNS = 128;
    localparam int IDLE_PCT = 31;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind  kind;
        t_in_item   item;
        logic       typed;
        t_out_item  word;
        logic [1:0] reg_index;
        logic [7:0] reg_value;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    fdcd_stream_if #(.T(t_in_item))   item_if ();
    fdcd_stream_if #(.T(t_out_item))  word_if ();
    fdcd_stream_if #(.T(t_cfg_write)) cfg_if ();

    flip_dot_column_driver #(.COLUMNS(COLUMNS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_if),
        .o_word  (word_if),
        .i_cfg   (cfg_if)
    );

    // Shadow copy of the driver state and registers
    logic [15:0] old_col [COLUMNS];
    logic [4:0]  sel_img;
    logic        clk_img;
    logic        rst_img;
    logic        clr_img;
    logic [15:0] rows_img;
    logic [31:0] flip_cnt;
    logic        diff_mode;
    logic [2:0]  n_panels;
    logic [7:0]  n_columns;

    t_out_item expected_words [$];
    t_row      stimulus_table [$];
    int        errors;
    logic      no_idle;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic push_word(input logic [7:0] wt, input logic [1:0] st, input logic lst);
        t_out_item w;
        w.select_lines = sel_img;
        w.clock_line   = clk_img;
        w.reset_line   = rst_img;
        w.clear_line   = clr_img;
        w.row_lines    = rows_img;
        w.wait_before  = wt;
        w.status       = st;
        w.flips_total  = flip_cnt;
        w.last         = lst;
        expected_words.push_back(w);
    endtask

    task automatic predict_drive_words(input t_in_item it);
        logic [31:0] mask;
        logic [15:0] old;
        logic [4:0]  changed;
        logic        omit_clear;
        logic        omit_set;
        if (it.action == ACT_SELECT) begin
            if (it.panel >= n_panels) begin
                push_word(8'd0, STATUS_BAD_PANEL, 1'b1);
            end else begin
                sel_img  = NO_SELECT;
                clk_img  = 1'b1;
                rst_img  = 1'b0;
                clr_img  = 1'b0;
                rows_img = '0;
                push_word(8'd0, STATUS_OK, 1'b0);
                mask    = ~(32'd1 << it.panel);
                sel_img = mask[4:0];
                rst_img = 1'b1;
                push_word(SHORT_WAIT, STATUS_OK, 1'b1);
            end
        end else if (it.column_index >= n_columns || it.column_index >= COLUMNS) begin
            push_word(8'd0, STATUS_BAD_COLUMN, 1'b1);
        end else begin
            old        = old_col[it.column_index[6:0]];
            changed    = 5'($countones(old ^ it.column_bits));
            omit_clear = diff_mode && ((old & ~it.column_bits) == 16'd0);
            omit_set   = diff_mode && (it.column_bits == 16'd0 || changed == 5'd0);
            flip_cnt   = flip_cnt + {27'd0, changed};
            old_col[it.column_index[6:0]] = it.column_bits;
            clk_img = 1'b0;
            push_word(it.pre_wait, STATUS_OK, 1'b0);
            sel_img = NO_SELECT;
            clk_img = 1'b1;
            if (!omit_clear) begin
                clr_img = 1'b1;
            end
            push_word(8'd0, STATUS_OK, 1'b0);
            if (!omit_clear) begin
                clr_img = 1'b0;
                push_word(it.clear_wait, STATUS_OK, 1'b0);
            end
            clk_img = 1'b0;
            push_word(omit_clear ? SHORT_WAIT : 8'd0, STATUS_OK, 1'b0);
            clk_img  = 1'b1;
            rows_img = it.column_bits;
            push_word(8'd0, STATUS_OK, 1'b0);
            rows_img = '0;
            push_word(omit_set ? SHORT_WAIT : it.set_wait, STATUS_OK, 1'b1);
        end
    endtask

    function automatic t_in_item mk_sel(input logic [2:0] p);
        t_in_item    it;
        logic [63:0] noise;
        noise     = {$urandom(), $urandom()};
        it        = noise[$bits(t_in_item)-1:0];
        it.action = ACT_SELECT;
        it.panel  = p;
        return it;
    endfunction

    function automatic t_in_item mk_col(input logic [7:0] x, input logic [15:0] bits,
                                        input logic [7:0] pre, input logic [7:0] clr,
                                        input logic [7:0] set);
        t_in_item    it;
        logic [63:0] noise;
        noise           = {$urandom(), $urandom()};
        it              = noise[$bits(t_in_item)-1:0];
        it.action       = ACT_RENDER;
        it.column_index = x;
        it.column_bits  = bits;
        it.pre_wait     = pre;
        it.clear_wait   = clr;
        it.set_wait     = set;
        return it;
    endfunction

    function automatic t_out_item err_word(input logic [1:0] st);
        t_out_item w;
        w.select_lines = NO_SELECT;
        w.clock_line   = 1'b1;
        w.reset_line   = 1'b1;
        w.clear_line   = 1'b0;
        w.row_lines    = '0;
        w.wait_before  = 8'd0;
        w.status       = st;
        w.flips_total  = '0;
        w.last         = 1'b1;
        return w;
    endfunction

    task automatic add_item(input t_in_item it);
        t_row r;
        r.kind  = ROW_ITEM;
        r.item  = it;
        r.typed = 1'b0;
        stimulus_table.push_back(r);
    endtask

    task automatic add_typed(input t_in_item it, input logic [1:0] st);
        t_row r;
        r.kind  = ROW_ITEM;
        r.item  = it;
        r.typed = 1'b1;
        r.word  = err_word(st);
        stimulus_table.push_back(r);
    endtask

    task automatic add_cfg(input logic [1:0] idx, input logic [7:0] val);
        t_row r;
        r.kind      = ROW_CFG;
        r.reg_index = idx;
        r.reg_value = val;
        stimulus_table.push_back(r);
    endtask

    function automatic logic [7:0] rand_wait();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_in_item rand_item();
        logic [7:0]  x;
        logic [15:0] bits;
        int          span;
        if ($urandom_range(0, 99) < 30) begin
            if ($urandom_range(0, 9) < 8) begin
                return mk_sel(3'($urandom_range(0, n_panels - 1)));
            end
            return mk_sel(3'($urandom_range(0, 7)));
        end
        span = (n_columns < COLUMNS) ? n_columns : COLUMNS;
        if (span > 0 && $urandom_range(0, 9) < 9) begin
            x = 8'($urandom_range(0, span - 1));
        end else begin
            x = 8'($urandom_range(0, 255));
        end
        bits = (x < COLUMNS) ? old_col[x[6:0]] : 16'd0;
        case ($urandom_range(0, 5))
            0: bits = 16'($urandom());
            1: ;
            2: bits = bits | 16'($urandom());
            3: bits = bits ^ (16'd1 << $urandom_range(0, 15));
            4: bits = 16'd0;
            default: bits = 16'hFFFF;
        endcase
        return mk_col(x, bits, rand_wait(), rand_wait(), rand_wait());
    endfunction

    task automatic send_item(input t_in_item it);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            item_if.valid = 1'b0;
            @(negedge i_clk);
        end
        item_if.valid = 1'b1;
        item_if.data  = it;
        @(posedge i_clk);
        while (!item_if.ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    task automatic drain_words();
        item_if.valid = 1'b0;
        while (expected_words.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [7:0] val);
        drain_words();
        cfg_if.valid      = 1'b1;
        cfg_if.data.index = idx;
        cfg_if.data.value = val;
        @(posedge i_clk);
        while (!cfg_if.ready) begin
            @(posedge i_clk);
        end
        case (idx)
            REG_DIFFERENTIAL:  diff_mode = val[0];
            REG_PANEL_COUNT:   n_panels  = val[2:0];
            REG_TOTAL_COLUMNS: n_columns = val;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    function automatic void check_field(input string name, input logic [31:0] e,
                                        input logic [31:0] a);
        if (e !== a) begin
            errors++;
            $error("%s: expected %0d, got %0d", name, e, a);
        end
    endfunction

    always @(negedge i_clk) begin
        word_if.ready = no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        t_out_item e;
        t_out_item a;
        if (i_rst_n && word_if.valid && word_if.ready) begin
            a = word_if.data;
            if (expected_words.size() == 0) begin
                errors++;
                $error("unexpected drive word %h", a);
            end else begin
                e = expected_words.pop_front();
                check_field("select_lines", 32'(e.select_lines), 32'(a.select_lines));
                check_field("clock_line", 32'(e.clock_line), 32'(a.clock_line));
                check_field("reset_line", 32'(e.reset_line), 32'(a.reset_line));
                check_field("clear_line", 32'(e.clear_line), 32'(a.clear_line));
                check_field("row_lines", 32'(e.row_lines), 32'(a.row_lines));
                check_field("wait_before", 32'(e.wait_before), 32'(a.wait_before));
                check_field("status", 32'(e.status), 32'(a.status));
                check_field("flips_total", e.flips_total, a.flips_total);
                check_field("last", 32'(e.last), 32'(a.last));
            end
        end
    end

    initial begin
        #1_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        item_if.valid = 1'b0;
        item_if.data  = '0;
        word_if.ready = 1'b0;
        cfg_if.valid  = 1'b0;
        cfg_if.data   = '0;
        errors        = 0;
        no_idle       = 1'b0;
        foreach (old_col[i]) begin
            old_col[i] = '0;
        end
        sel_img   = NO_SELECT;
        clk_img   = 1'b1;
        rst_img   = 1'b1;
        clr_img   = 1'b0;
        rows_img  = '0;
        flip_cnt  = '0;
        diff_mode = 1'b0;
        n_panels  = 3'd1;
        n_columns = 8'd0;

        // Reset defaults: one panel, no columns
        add_typed(mk_sel(3'd3), STATUS_BAD_PANEL);
        add_typed(mk_sel(3'd7), STATUS_BAD_PANEL);
        add_typed(mk_col(8'd0, 16'hFFFF, 8'd1, 8'd1, 8'd1), STATUS_BAD_COLUMN);
        add_typed(mk_col(8'd255, 16'h1234, 8'd9, 8'd9, 8'd9), STATUS_BAD_COLUMN);
        add_item(mk_sel(3'd0));
        add_cfg(REG_PANEL_COUNT, 8'd5);
        add_cfg(REG_TOTAL_COLUMNS, 8'd128);
        add_cfg(REG_DIFFERENTIAL, 8'd0);
        add_item(mk_sel(3'd4));
        add_item(mk_sel(3'd5));
        add_item(mk_col(8'd0, 16'hFFFF, 8'd255, 8'd255, 8'd255));
        add_item(mk_col(8'd127, 16'h0000, 8'd0, 8'd0, 8'd0));
        add_item(mk_col(8'd128, 16'hFFFF, 8'd7, 8'd7, 8'd7));
        add_item(mk_col(8'd0, 16'h0000, 8'd255, 8'd255, 8'd255));
        add_cfg(REG_DIFFERENTIAL, 8'd1);
        add_item(mk_col(8'd1, 16'h00F0, 8'd3, 8'd4, 8'd5));
        add_item(mk_col(8'd1, 16'h00F0, 8'd3, 8'd4, 8'd5));
        add_item(mk_col(8'd1, 16'h0000, 8'd3, 8'd4, 8'd5));
        add_item(mk_col(8'd1, 16'hA5A5, 8'd3, 8'd4, 8'd5));
        add_item(mk_col(8'd1, 16'h5A5A, 8'd3, 8'd4, 8'd5));
        add_item(mk_col(8'd127, 16'hFFFF, 8'd255, 8'd255, 8'd255));
        add_cfg(REG_PANEL_COUNT, 8'd7);
        add_cfg(REG_TOTAL_COLUMNS, 8'd255);
        add_item(mk_sel(3'd5));
        add_item(mk_sel(3'd7));
        add_item(mk_col(8'd200, 16'hFFFF, 8'd1, 8'd1, 8'd1));
        add_item(mk_col(8'd127, 16'h0000, 8'd0, 8'd0, 8'd0));
        add_cfg(REG_PANEL_COUNT, 8'd1);
        add_cfg(REG_TOTAL_COLUMNS, 8'd1);
        add_cfg(REG_DIFFERENTIAL, 8'd0);
        add_item(mk_sel(3'd0));
        add_item(mk_sel(3'd1));
        add_item(mk_col(8'd0, 16'h8001, 8'd10, 8'd20, 8'd30));
        add_item(mk_col(8'd1, 16'h8001, 8'd10, 8'd20, 8'd30));

        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (stimulus_table[i]) begin
            if (stimulus_table[i].kind == ROW_CFG) begin
                write_register(stimulus_table[i].reg_index, stimulus_table[i].reg_value);
            end else begin
                if (stimulus_table[i].typed) begin
                    expected_words.push_back(stimulus_table[i].word);
                end else begin
                    predict_drive_words(stimulus_table[i].item);
                end
                send_item(stimulus_table[i].item);
            end
        end

        for (int phase = 0; phase < 6; phase++) begin
            write_register(REG_DIFFERENTIAL, 8'($urandom_range(0, 1)));
            write_register(REG_PANEL_COUNT,
                8'(($urandom_range(0, 3) == 0) ? $urandom_range(6, 7) : $urandom_range(1, 5)));
            case ($urandom_range(0, 4))
                0: write_register(REG_TOTAL_COLUMNS, 8'($urandom_range(1, 8)));
                1: write_register(REG_TOTAL_COLUMNS, 8'd128);
                2: write_register(REG_TOTAL_COLUMNS, 8'($urandom_range(129, 255)));
                default: write_register(REG_TOTAL_COLUMNS, 8'($urandom_range(1, 128)));
            endcase
            no_idle = (phase == 2);
            for (int n = 0; n < 41; n++) begin
                t_in_item it;
                it = rand_item();
                predict_drive_words(it);
                send_item(it);
            end
        end

        item_if.valid = 1'b0;
        no_idle = 1'b0;
        while (expected_words.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (10) @(negedge i_clk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/fdcd_pkg.sv
rtl/core/fdcd_stream_if.sv
rtl/core/fdcd_column_store.sv
rtl/core/flip_dot_column_driver.sv
tb/sv/testbench.sv
